// ===== sv/positional_array_list_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Positional array list -- assertion macros
// Shorthand for concurrent checks, with and without reset masking.
// ----------------------------------------------------------------------------
`ifndef POSITIONAL_ARRAY_LIST_UNIT_MACROS_SVH
`define POSITIONAL_ARRAY_LIST_UNIT_MACROS_SVH

// check masked while reset is high
`define PAL_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// check that also holds across reset
`define PAL_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/pal_pkg.sv =====
// ----------------------------------------------------------------------------
// pal_pkg
// Shared sizes, codes and types of the positional array list.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pal_pkg;

   localparam int DEPTH       = 64;
   localparam int ENTRY_WIDTH = 32;
   localparam int IDX_W       = $clog2(DEPTH);
   localparam int CNT_W       = 7;

   // gather tree: group size per first OR level
   localparam int GRP         = 8;
   localparam int NGRP        = (DEPTH + GRP - 1) / GRP;

   // word layout
   localparam int REQ_W          = 48;
   localparam int RSP_W          = 48;
   localparam int RSP_STATUS_LSB = 32;
   localparam int RSP_COUNT_LSB  = 34;

   typedef enum logic [2:0] {
      CMD_INS_FRONT = 3'd0,
      CMD_INS_BACK  = 3'd1,
      CMD_INS_AT    = 3'd2,
      CMD_REM_FRONT = 3'd3,
      CMD_REM_BACK  = 3'd4,
      CMD_REM_AT    = 3'd5
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2,
      ST_RANGE = 2'd3
   } status_type;

   // broadcast from the control to every cell
   typedef struct packed {
      logic                   adv;
      logic                   ins;
      logic                   rem;
      logic [CNT_W-1:0]       at;
      logic [ENTRY_WIDTH-1:0] entry;
   } pal_ctrl_type;

endpackage

`default_nettype wire

// ===== sv/positional_array_list_unit.sv =====
// Each response is registered through v1_ff, v2_ff and rsp_valid_ff in turn.
// Throughput: one command per cycle unless a response stalls; the cell row
//   shifts at once and the removed word drains through a two-level
//   registered OR tree. Backpressure stalls the whole response pipeline;
//   req_tready is low only while a response waits and rsp_tready is low.
// Reset (synchronous, high) empties the list; slot contents are not cleared.
// ----------------------------------------------------------------------------
// positional_array_list_unit
// Bounded ordered list as a row of shifting cells, with insert and remove
// at front, back or a given position.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module positional_array_list_unit
   import pal_pkg::*;
(
   input  wire  logic             clock,
   input  wire  logic             reset,
   // request word, low bit up: cmd[2:0], pos[9:3], entry[41:10], zero fill
   input  wire  logic             req_tvalid,
   output logic                   req_tready,
   input  wire  logic [REQ_W-1:0] req_tdata,
   // response word, low bit up: removed_entry[31:0], status[33:32],
   // count[40:34], zero fill
   output logic                   rsp_tvalid,
   input  wire  logic             rsp_tready,
   output logic       [RSP_W-1:0] rsp_tdata
);

   // ------------------------------------------------------------------
   // request fields
   // ------------------------------------------------------------------
   logic [2:0]             req_cmd;
   logic [CNT_W-1:0]       req_pos;
   logic [ENTRY_WIDTH-1:0] req_entry;

   assign req_cmd   = req_tdata[2:0];
   assign req_pos   = req_tdata[9:3];
   assign req_entry = req_tdata[41:10];

   // ------------------------------------------------------------------
   // control state and pipeline
   // ------------------------------------------------------------------
   logic [CNT_W-1:0]       count_ff, count_in;
   logic                   v1_ff, v2_ff, rsp_valid_ff;
   status_type             st1_ff, st2_ff, rsp_st_ff, status_in;
   logic [CNT_W-1:0]       cnt1_ff, cnt2_ff, rsp_cnt_ff;
   logic [ENTRY_WIDTH-1:0] rsp_ent_ff;
   logic [ENTRY_WIDTH-1:0] taken;

   logic                   adv, accept;
   logic                   is_ins, is_rem, full, empty;
   logic [CNT_W-1:0]       at;
   logic                   ins_ok, rem_ok;
   pal_ctrl_type           ctrl;

   // whole pipeline moves unless a finished response is being held
   assign adv        = !rsp_valid_ff || rsp_tready;
   assign req_tready = adv;
   assign accept     = req_tvalid && req_tready;

   assign full  = (count_ff == CNT_W'(DEPTH));
   assign empty = (count_ff == '0);

   // command decode: target position and kind
   always_comb begin
      is_ins = 1'b0;
      is_rem = 1'b0;
      at     = '0;
      unique case (req_cmd)
         CMD_INS_FRONT: begin
            is_ins = 1'b1;
         end
         CMD_INS_BACK: begin
            is_ins = 1'b1;
            at     = count_ff;
         end
         CMD_INS_AT: begin
            is_ins = 1'b1;
            at     = req_pos;
         end
         CMD_REM_FRONT: begin
            is_rem = 1'b1;
         end
         CMD_REM_BACK: begin
            is_rem = 1'b1;
            at     = empty ? '0 : count_ff - 1'b1;
         end
         CMD_REM_AT: begin
            is_rem = 1'b1;
            at     = req_pos;
         end
         default: begin
            // unused codes: no change, ok
         end
      endcase
   end

   // checks: full / empty win over a bad position
   always_comb begin
      status_in = ST_OK;
      if (is_ins) begin
         if (full) begin
            status_in = ST_FULL;
         end else if (at > count_ff) begin
            status_in = ST_RANGE;
         end
      end else if (is_rem) begin
         if (empty) begin
            status_in = ST_EMPTY;
         end else if (at >= count_ff) begin
            status_in = ST_RANGE;
         end
      end
      ins_ok   = is_ins && (status_in == ST_OK);
      rem_ok   = is_rem && (status_in == ST_OK);
      count_in = count_ff;
      if (ins_ok) begin
         count_in = count_ff + 1'b1;
      end else if (rem_ok) begin
         count_in = count_ff - 1'b1;
      end
   end

   assign ctrl.adv   = adv;
   assign ctrl.ins   = accept && ins_ok;
   assign ctrl.rem   = accept && rem_ok;
   assign ctrl.at    = at;
   assign ctrl.entry = req_entry;

   // ------------------------------------------------------------------
   // cell row: each cell sees its neighbors' slots
   // ------------------------------------------------------------------
   logic [DEPTH-1:0][ENTRY_WIDTH-1:0] slot_val, cap_val;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [ENTRY_WIDTH-1:0] left_val, right_val;

      if (i == 0) begin : g_first
         assign left_val = '0;
      end else begin : g_left
         assign left_val = slot_val[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
         assign right_val = '0;
      end else begin : g_right
         assign right_val = slot_val[i+1];
      end

      pal_cell u_cell (
         .clock     (clock),
         .cell_idx  (IDX_W'(i)),
         .ctrl      (ctrl),
         .left_val  (left_val),
         .right_val (right_val),
         .slot_val  (slot_val[i]),
         .cap_val   (cap_val[i])
      );
   end

   // removed word: cell capture -> group OR -> response register
   pal_gather u_gather (
      .clock (clock),
      .adv   (adv),
      .cap   (cap_val),
      .taken (taken)
   );

   // ------------------------------------------------------------------
   // control registers
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            count_ff <= count_in;
         end
         if (adv) begin
            v1_ff        <= accept;
            v2_ff        <= v1_ff;
            rsp_valid_ff <= v2_ff;
         end
      end
   end

   // status / count ride alongside the gather tree
   always_ff @(posedge clock) begin
      if (adv) begin
         st1_ff     <= status_in;
         cnt1_ff    <= count_in;
         st2_ff     <= st1_ff;
         cnt2_ff    <= cnt1_ff;
         rsp_st_ff  <= st2_ff;
         rsp_cnt_ff <= cnt2_ff;
         rsp_ent_ff <= taken;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(RSP_W - CNT_W - 2 - ENTRY_WIDTH)'(0), rsp_cnt_ff,
                        rsp_st_ff, rsp_ent_ff};

endmodule

`default_nettype wire

// ===== sv/pal_cell.sv =====
// ----------------------------------------------------------------------------
// pal_cell
// One list slot: shifts up on insert, down on remove, captures on hit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pal_cell
   import pal_pkg::*;
(
   input  wire  logic                   clock,
   input  wire  logic [IDX_W-1:0]       cell_idx,
   input  wire  pal_ctrl_type           ctrl,
   input  wire  logic [ENTRY_WIDTH-1:0] left_val,
   input  wire  logic [ENTRY_WIDTH-1:0] right_val,
   output logic       [ENTRY_WIDTH-1:0] slot_val,
   output logic       [ENTRY_WIDTH-1:0] cap_val
);

   logic [ENTRY_WIDTH-1:0] slot_ff, slot_in;
   logic [ENTRY_WIDTH-1:0] cap_ff,  cap_in;
   logic [CNT_W-1:0]       idx_ext;
   logic                   at_or_above, hit;

   assign idx_ext     = CNT_W'(cell_idx);
   assign at_or_above = (idx_ext >= ctrl.at);
   assign hit         = (idx_ext == ctrl.at);

   always_comb begin
      slot_in = slot_ff;
      if (ctrl.ins && hit) begin
         slot_in = ctrl.entry;
      end else if (ctrl.ins && at_or_above) begin
         slot_in = left_val;
      end else if (ctrl.rem && at_or_above) begin
         slot_in = right_val;
      end
      cap_in = (ctrl.rem && hit) ? slot_ff : '0;
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
      if (ctrl.adv) begin
         cap_ff <= cap_in;
      end
   end

   assign slot_val = slot_ff;
   assign cap_val  = cap_ff;

endmodule

`default_nettype wire

// ===== sv/pal_gather.sv =====
// ----------------------------------------------------------------------------
// pal_gather
// Registered OR tree that collects the one captured entry from the cells.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pal_gather
   import pal_pkg::*;
(
   input  wire  logic                              clock,
   input  wire  logic                              adv,
   input  wire  logic [DEPTH-1:0][ENTRY_WIDTH-1:0] cap,
   output logic       [ENTRY_WIDTH-1:0]            taken
);

   logic [NGRP*GRP-1:0][ENTRY_WIDTH-1:0] cap_pad;
   logic [NGRP-1:0][ENTRY_WIDTH-1:0]     grp_ff, grp_in;

   always_comb begin
      cap_pad            = '0;
      cap_pad[DEPTH-1:0] = cap;
      grp_in             = '0;
      for (int g = 0; g < NGRP; g++) begin
         for (int k = 0; k < GRP; k++) begin
            grp_in[g] = grp_in[g] | cap_pad[g*GRP + k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         grp_ff <= grp_in;
      end
   end

   // second level, at most eight groups
   always_comb begin
      taken = '0;
      for (int g = 0; g < NGRP; g++) begin
         taken = taken | grp_ff[g];
      end
   end

endmodule

`default_nettype wire

// ===== sv/pal_checker.sv =====
// ----------------------------------------------------------------------------
// pal_checker
// Port-level checks of the positional array list, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "positional_array_list_unit_macros.svh"

module pal_checker
   import pal_pkg::*;
(
   input  wire  logic             clock,
   input  wire  logic             reset,
   input  wire  logic             req_tready,
   input  wire  logic             rsp_tvalid,
   input  wire  logic             rsp_tready,
   input  wire  logic [RSP_W-1:0] rsp_tdata
);

   logic [1:0]       rsp_status;
   logic [CNT_W-1:0] rsp_count;

   assign rsp_status = rsp_tdata[RSP_STATUS_LSB +: 2];
   assign rsp_count  = rsp_tdata[RSP_COUNT_LSB +: CNT_W];

   // a stalled response holds its word
   `PAL_ASSERT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata), "response changed while stalled")

   // failed commands return no entry
   `PAL_ASSERT(a_err_no_entry, clock, reset, rsp_tvalid && rsp_status != ST_OK |-> rsp_tdata[ENTRY_WIDTH-1:0] == '0, "error response carries an entry")

   // list never reports more than its depth
   `PAL_ASSERT(a_count_max, clock, reset, rsp_tvalid |-> rsp_count <= CNT_W'(DEPTH), "count beyond depth")

   // with no response pending the input is open
   `PAL_ASSERT(a_ready_idle, clock, reset, !rsp_tvalid |-> req_tready, "input blocked with empty output")

   // nothing comes out right after reset
   `PAL_ASSERT_ALWAYS(a_reset_quiet, clock, reset |=> !rsp_tvalid, "response right after reset")

endmodule

bind positional_array_list_unit pal_checker u_pal_checker (.*);

`default_nettype wire
